[hdl/ffbu_pkg.sv]
// ----------------------------------------------------------------------------
// ffbu_pkg
// Shared constants and types for the flag-framed byte unstuffer. It holds the
// framing bytes, the derived counter widths, the status codes and the result
// word that passes from the deframer to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ffbu_pkg;

  // Number of frame slots and the largest decoded payload per frame.
  localparam int SLOT_COUNT  = 16;
  localparam int FRAME_BYTES = 32;

  // Internal widths follow from the sizing above.
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int DCNT_W = $clog2(FRAME_BYTES + 1);

  // Port field widths are fixed by the interface.
  localparam int BYTE_W   = 8;
  localparam int SLOTF_W  = 4;
  localparam int LENF_W   = 6;
  localparam int STATUS_W = 2;

  // Framing bytes.
  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR   = 8'h20;

  // End-of-frame status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_ESC_ABORT  = 2'd2
  } ffbu_status_t;

  // One result word from the deframer.
  typedef struct packed {
    logic                emit;
    logic [BYTE_W-1:0]   data_byte;
    logic                frame_end;
    logic [SLOTF_W-1:0]  slot;
    logic [LENF_W-1:0]   frame_length;
    ffbu_status_t        status;
  } ffbu_result_t;

endpackage

`default_nettype wire

[hdl/ffbu_deframer.sv]
// ----------------------------------------------------------------------------
// ffbu_deframer
// Frame state and per-word decode. When step is high the word on rx_byte is
// consumed: the frame state updates at the clock edge and the result word
// describes the payload byte or end-of-frame item it produces, if any.
// ----------------------------------------------------------------------------
`default_nettype none

module ffbu_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step,
  input  wire logic [ffbu_pkg::BYTE_W-1:0] rx_byte,
  output ffbu_pkg::ffbu_result_t           result
);
  import ffbu_pkg::*;

  // Frame state.
  logic              in_frame_r, in_frame_nxt;
  logic              esc_r, esc_nxt;
  logic              got_byte_r, got_byte_nxt;
  logic [DCNT_W-1:0] dcount_r, dcount_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  logic              is_flag;
  logic              is_esc;
  logic [SLOT_W-1:0] slot_inc;

  assign is_flag  = (rx_byte == FLAG_BYTE);
  assign is_esc   = (rx_byte == ESC_BYTE);
  assign slot_inc = (slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0 : slot_r + 1'b1;

  // Decode one word and work out the next frame state.
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    got_byte_nxt = got_byte_r;
    dcount_nxt   = dcount_r;
    slot_nxt     = slot_r;

    result              = '0;
    result.slot         = SLOTF_W'(slot_r);
    result.frame_length = LENF_W'(dcount_r);
    result.status       = ST_OK;

    if (step) begin
      if (!in_frame_r) begin
        // Hunting: only a flag opens a frame.
        if (is_flag) begin
          in_frame_nxt = 1'b1;
          esc_nxt      = 1'b0;
          got_byte_nxt = 1'b0;
          dcount_nxt   = '0;
        end
      end else if (is_flag) begin
        if (esc_r) begin
          // An escape followed by a flag aborts the frame.
          result.emit      = 1'b1;
          result.frame_end = 1'b1;
          result.status    = ST_ESC_ABORT;
          in_frame_nxt     = 1'b0;
          esc_nxt          = 1'b0;
          got_byte_nxt     = 1'b0;
          dcount_nxt       = '0;
        end else if (got_byte_r) begin
          // Closing flag ends the frame and moves to the next slot.
          result.emit      = 1'b1;
          result.frame_end = 1'b1;
          in_frame_nxt     = 1'b0;
          esc_nxt          = 1'b0;
          got_byte_nxt     = 1'b0;
          dcount_nxt       = '0;
          slot_nxt         = slot_inc;
        end
      end else begin
        got_byte_nxt = 1'b1;
        if (is_esc && !esc_r) begin
          esc_nxt = 1'b1;
        end else if (dcount_r >= DCNT_W'(FRAME_BYTES)) begin
          // Buffer is full: drop the byte and abort the frame.
          result.emit      = 1'b1;
          result.frame_end = 1'b1;
          result.status    = ST_OVERFLOW;
          in_frame_nxt     = 1'b0;
          esc_nxt          = 1'b0;
          got_byte_nxt     = 1'b0;
          dcount_nxt       = '0;
        end else begin
          // Ordinary payload byte, unescaped when needed.
          result.emit         = 1'b1;
          result.data_byte    = esc_r ? (rx_byte ^ ESC_XOR) : rx_byte;
          result.frame_length = '0;
          esc_nxt             = 1'b0;
          dcount_nxt          = dcount_r + 1'b1;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      got_byte_r <= 1'b0;
      dcount_r   <= '0;
      slot_r     <= '0;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      got_byte_r <= got_byte_nxt;
      dcount_r   <= dcount_nxt;
      slot_r     <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/flag_framed_byte_unstuffer_core.sv]
// ----------------------------------------------------------------------------
// flag_framed_byte_unstuffer_core
// HDLC-like deframer: removes flag framing and byte stuffing from a stream of
// received bytes and reports payload bytes and end-of-frame items per slot.
//
//   Channel | Ports                                         | Direction
//   --------+-----------------------------------------------+----------
//   in      | in_valid, in_ready, in_rx_byte                | sink
//   out     | out_valid, out_ready, out_data_byte,          | source
//           | out_frame_end, out_slot, out_frame_length,    |
//           | out_status                                    |
//
// One word is accepted per cycle unless an output stall backs up into the
// input register. A word passes through an input register, is decoded when
// it moves on, and its result, if it has one, lands in the output register.
// Reset (rst_n, synchronous) clears the frame state, the slot and both valid
// bits. A stall on the output holds the input register and drops in_ready
// only once it holds a word as well.
// ----------------------------------------------------------------------------
`default_nettype none

module flag_framed_byte_unstuffer_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ffbu_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ffbu_pkg::BYTE_W-1:0]        out_data_byte,
  output logic                               out_frame_end,
  output logic [ffbu_pkg::SLOTF_W-1:0]       out_slot,
  output logic [ffbu_pkg::LENF_W-1:0]        out_frame_length,
  output logic [ffbu_pkg::STATUS_W-1:0]      out_status
);
  import ffbu_pkg::*;

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  ffbu_result_t      res_r;
  ffbu_result_t      dec_res;
  logic              advance;

  // The held word moves on when the output register can take a result.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_rx_byte;
    end
  end

  ffbu_deframer u_deframer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .result  (dec_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && dec_res.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec_res.emit) begin
      res_r <= dec_res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_data_byte    = res_r.data_byte;
  assign out_frame_end    = res_r.frame_end;
  assign out_slot         = res_r.slot;
  assign out_frame_length = res_r.frame_length;
  assign out_status       = res_r.status;

endmodule

`default_nettype wire

[verif/tb_flag_framed_byte_unstuffer_core.sv]
// ----------------------------------------------------------------------------
// tb_flag_framed_byte_unstuffer_core
// Self-checking bench for the flag-framed byte unstuffer. A short directed
// stream and then a long run of random stuffed frames are pushed through the
// input channel with random gaps. A local deframer model predicts every
// result word, and the monitor checks each word against the oldest
// prediction while the output side stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_flag_framed_byte_unstuffer_core;
  import ffbu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_LIMIT    = 63;
  localparam int STALL_LIMIT  = 2000;
  localparam int TARGET_BYTES = 1400;

  // One predicted result word.
  typedef struct packed {
    logic [BYTE_W-1:0]  data_byte;
    logic               frame_end;
    logic [SLOTF_W-1:0] slot;
    logic [LENF_W-1:0]  frame_length;
    ffbu_status_t       status;
  } deframed_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_data_byte;
  logic                out_frame_end;
  logic [SLOTF_W-1:0]  out_slot;
  logic [LENF_W-1:0]   out_frame_length;
  logic [STATUS_W-1:0] out_status;

  // Line bytes waiting to be driven and result words still to arrive.
  logic [BYTE_W-1:0] line_bytes[$];
  deframed_word_t    expected_words[$];

  // Deframer model state.
  bit in_frame_m;
  bit escape_m;
  int raw_count_m;
  int decoded_count_m;
  int slot_m;

  int mismatch_count;
  int framed_bytes;
  int send_gap;
  int recv_wait;
  int idle_cycles;
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;

  flag_framed_byte_unstuffer_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data_byte    (out_data_byte),
    .out_frame_end    (out_frame_end),
    .out_slot         (out_slot),
    .out_frame_length (out_frame_length),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // Queue one expected word using the current slot of the model.
  function automatic void expect_word(logic [BYTE_W-1:0] data, logic is_end,
                                      int len, ffbu_status_t st);
    deframed_word_t w;
    w.data_byte    = data;
    w.frame_end    = is_end;
    w.slot         = slot_m[SLOTF_W-1:0];
    w.frame_length = len[LENF_W-1:0];
    w.status       = st;
    expected_words.push_back(w);
  endfunction

  function automatic void return_to_hunt();
    in_frame_m      = 1'b0;
    escape_m        = 1'b0;
    raw_count_m     = 0;
    decoded_count_m = 0;
  endfunction

  // Advance the deframer model by one accepted line byte.
  function automatic void deframe_byte(logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] d;
    if (!in_frame_m) begin
      // Hunting: only a flag matters, and it opens a frame.
      if (b == FLAG_BYTE) begin
        in_frame_m      = 1'b1;
        escape_m        = 1'b0;
        raw_count_m     = 1;
        decoded_count_m = 0;
      end
    end else if (b == FLAG_BYTE) begin
      if (escape_m) begin
        expect_word('0, 1'b1, decoded_count_m, ST_ESC_ABORT);
        return_to_hunt();
      end else if (raw_count_m != 1) begin
        // A flag after a frame byte closes the frame; one right after the opening flag keeps it open.
        expect_word('0, 1'b1, decoded_count_m, ST_OK);
        return_to_hunt();
        slot_m = (slot_m + 1) % SLOT_COUNT;
      end
    end else begin
      if (raw_count_m < RAW_LIMIT) raw_count_m++;
      if (b == ESC_BYTE && !escape_m) begin
        escape_m = 1'b1;
      end else if (decoded_count_m >= FRAME_BYTES) begin
        expect_word('0, 1'b1, decoded_count_m, ST_OVERFLOW);
        return_to_hunt();
      end else begin
        d = escape_m ? (b ^ ESC_XOR) : b;
        escape_m = 1'b0;
        expect_word(d, 1'b0, 0, ST_OK);
        decoded_count_m++;
      end
    end
  endfunction

  // Stimulus helpers: raw byte inside framing, and a payload byte stuffed
  // when it collides with a framing byte.
  task automatic send_raw(logic [BYTE_W-1:0] b);
    line_bytes.push_back(b);
    framed_bytes++;
  endtask

  task automatic send_payload(logic [BYTE_W-1:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      send_raw(ESC_BYTE);
      send_raw(b ^ ESC_XOR);
    end else begin
      send_raw(b);
    end
  endtask

  // Driver: one word per handshake, random gap drawn for each word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (line_bytes.size() > 0) begin
          in_valid   <= 1'b1;
          in_rx_byte <= line_bytes.pop_front();
          if ($urandom_range(0, 63) == 0) send_idle_en = ~send_idle_en;
          send_gap = send_idle_en ? $urandom_range(0, 4) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string field, logic [BYTE_W-1:0] expv,
                             logic [BYTE_W-1:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0h, actual %0h", field, expv, actv);
      mismatch_count++;
    end
  endtask

  // Monitor: compare each accepted word with the oldest prediction.
  always @(posedge clk) begin
    deframed_word_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: data_byte %0h frame_end %0b slot %0d len %0d status %0d",
                 out_data_byte, out_frame_end, out_slot, out_frame_length, out_status);
          mismatch_count++;
        end else begin
          w = expected_words.pop_front();
          check_field("data_byte", w.data_byte, out_data_byte);
          check_field("frame_end", BYTE_W'(w.frame_end), BYTE_W'(out_frame_end));
          check_field("slot", BYTE_W'(w.slot), BYTE_W'(out_slot));
          check_field("frame_length", BYTE_W'(w.frame_length),
                      BYTE_W'(out_frame_length));
          check_field("status", BYTE_W'(w.status), BYTE_W'(out_status));
        end
        if ($urandom_range(0, 63) == 0) recv_idle_en = ~recv_idle_en;
        recv_wait = recv_idle_en ? $urandom_range(0, 4) : 0;
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int plen;
    int pick;
    logic [BYTE_W-1:0] b;

    return_to_hunt();
    slot_m = 0;

    // Directed: noise while hunting, empty-frame flags, field extremes and
    // every escape form, a normal close, an escape followed by a flag, then a short frame.
    line_bytes.push_back(8'h00);
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(ESC_BYTE);
    send_raw(FLAG_BYTE);
    send_raw(FLAG_BYTE);
    send_raw(FLAG_BYTE);
    send_raw(8'h00);
    send_raw(8'hFF);
    send_payload(FLAG_BYTE);
    send_payload(ESC_BYTE);
    send_raw(ESC_BYTE);
    send_raw(ESC_BYTE);
    send_raw(ESC_BYTE);
    send_raw(8'hAA);
    send_raw(8'h55);
    send_raw(FLAG_BYTE);
    send_raw(FLAG_BYTE);
    send_raw(8'h20);
    send_raw(ESC_BYTE);
    send_raw(FLAG_BYTE);
    send_raw(FLAG_BYTE);
    send_raw(8'h01);
    send_raw(FLAG_BYTE);

    // Random frames: mostly well formed, some long enough to overflow,
    // some ending in an escape, and some bursts of line noise.
    while (framed_bytes < TARGET_BYTES) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        repeat ($urandom_range(1, 6)) line_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end else begin
        send_raw(FLAG_BYTE);
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) send_raw(FLAG_BYTE);
        pick = $urandom_range(0, 9);
        if (pick < 8) plen = $urandom_range(0, 12);
        else if (pick == 8) plen = $urandom_range(28, FRAME_BYTES);
        else plen = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 6);
        repeat (plen) begin
          case ($urandom_range(0, 5))
            0: send_payload($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
            1: begin
              // Escape of an arbitrary byte, a double escape included.
              b = BYTE_W'($urandom_range(0, 255));
              if (b == FLAG_BYTE) b = 8'h00;
              send_raw(ESC_BYTE);
              send_raw(b);
            end
            default: send_payload(BYTE_W'($urandom_range(0, 255)));
          endcase
        end
        if ($urandom_range(0, 9) == 0) send_raw(ESC_BYTE);
        send_raw(FLAG_BYTE);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all words to be accepted and all results to arrive.
    while (line_bytes.size() > 0 || in_valid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
